// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file acfu_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/acfu_pkg.sv =====
// shared types, character codes and helpers of the ansi color code filter
// no dependencies
`default_nettype none

package acfu_pkg;

  localparam int PARAM_DEPTH     = 24;
  localparam int PARAM_DEPTH_MAX = 64;
  localparam int CNT_W_MAX       = $clog2(PARAM_DEPTH_MAX + 1);
  localparam int CMD_FIFO_DEPTH  = 2;
  localparam int RES_FIFO_DEPTH  = 2;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;

  localparam logic [4:0] KEEP_LIMIT = 5'd30;

  // register index, taken from paddr[2]
  localparam logic REG_PASS_THROUGH = 1'b0;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_ESC_BYTE,
    OP_SGR,
    OP_CSI_OTHER
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [7:0]             data;
    logic [CNT_W_MAX-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/acfu_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module acfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/acfu_fifo.sv =====
// small register queue with full and empty flags
// no dependencies
`default_nettype none

module acfu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/acfu_front.sv =====
// front end: takes text bytes, tracks escape state, fills the parameter store
// depends on acfu_pkg
`default_nettype none

module acfu_front #(
  parameter int PARAM_DEPTH = acfu_pkg::PARAM_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           pass_through,
  input  wire logic                           in_push,
  input  wire logic [7:0]                     in_byte,
  output logic                                in_full,
  input  wire logic                           cmd_full,
  output logic                                cmd_push,
  output acfu_pkg::cmd_t                      cmd,
  output logic                                ram_we,
  output logic      [$clog2(PARAM_DEPTH)-1:0] ram_waddr,
  output logic      [7:0]                     ram_wdata,
  input  wire logic                           walk_done
);

  localparam int AW = $clog2(PARAM_DEPTH);
  localparam int CW = $clog2(PARAM_DEPTH + 1);

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_CSI  = 2'd2;

  logic [1:0]        mode_r, mode_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              accept;
  logic              store_ok;
  acfu_pkg::cmd_op_t cmd_op;
  logic [CW-1:0]     cmd_count;

  // hold off csi bytes while the back end still walks the store
  assign in_full  = cmd_full || (mode_r == MODE_CSI && busy_r && !pass_through);
  assign accept   = in_push && !in_full;
  assign store_ok = (in_byte != acfu_pkg::CH_M) && (cnt_r < CW'(PARAM_DEPTH))
                    && !acfu_pkg::is_letter(in_byte);

  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_wdata = in_byte;

  assign cmd.op    = cmd_op;
  assign cmd.data  = in_byte;
  assign cmd.count = (acfu_pkg::CNT_W_MAX)'(cmd_count);

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    cmd_push  = 1'b0;
    cmd_op    = acfu_pkg::OP_BYTE;
    cmd_count = cnt_r;
    ram_we    = 1'b0;
    if (walk_done) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      if (pass_through) begin
        cmd_push = 1'b1;
      end else begin
        unique case (mode_r)
          MODE_ESC: begin
            if (in_byte == acfu_pkg::CH_LBRACKET) begin
              mode_nxt = MODE_CSI;
            end else begin
              mode_nxt = MODE_TEXT;
              cmd_push = 1'b1;
              cmd_op   = acfu_pkg::OP_ESC_BYTE;
            end
          end
          MODE_CSI: begin
            if (store_ok) begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              cmd_push = 1'b1;
              cmd_op   = (in_byte == acfu_pkg::CH_M) ? acfu_pkg::OP_SGR
                                                     : acfu_pkg::OP_CSI_OTHER;
              cnt_nxt  = '0;
              mode_nxt = MODE_TEXT;
              busy_nxt = 1'b1;
            end
          end
          default: begin
            if (in_byte == acfu_pkg::CH_ESC) begin
              mode_nxt = MODE_ESC;
            end else begin
              mode_nxt = MODE_TEXT;
              cmd_push = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/acfu_back.sv =====
// back end: carries out queued commands, scans and re-emits csi parameters
// depends on acfu_pkg, acfu_ram
`default_nettype none

module acfu_back #(
  parameter int PARAM_DEPTH = acfu_pkg::PARAM_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_empty,
  input  wire acfu_pkg::cmd_t                 cmd,
  output logic                                cmd_pop,
  output logic      [$clog2(PARAM_DEPTH)-1:0] ram_raddr,
  input  wire logic [7:0]                     ram_rdata,
  input  wire logic                           res_full,
  output logic                                res_push,
  output acfu_pkg::res_t                      res,
  output logic                                walk_done
);

  localparam int AW = $clog2(PARAM_DEPTH);
  localparam int CW = $clog2(PARAM_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ESC  = 3'd1;
  localparam logic [2:0] ST_LB   = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_COPY = 3'd4;
  localparam logic [2:0] ST_TAIL = 3'd5;

  localparam logic [1:0] EV_BLANK = 2'd0;
  localparam logic [1:0] EV_DIGIT = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  logic [2:0]    state_r, state_nxt;
  logic [7:0]    tail_r, tail_nxt;
  logic          walk_r, walk_nxt;
  logic          is_m_r, is_m_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic          ph_r, ph_nxt;
  logic          nonempty_r, nonempty_nxt;
  logic [1:0]    ev_r, ev_nxt;
  logic          neg_r, neg_nxt;
  logic [4:0]    mag_r, mag_nxt;
  logic          any_r, any_nxt;
  logic          at_start_r, at_start_nxt;
  logic          keep_r, keep_nxt;
  logic          emitted_r, emitted_nxt;

  logic          emit_v, emit_last, scan_end;
  logic [7:0]    emit_data;
  logic          f_we;
  logic [0:0]    f_rdata;
  logic          keep_cur, is_digit, is_blank, is_sign;
  logic [8:0]    mag_sum;
  logic [4:0]    mag_step;

  assign ram_raddr = idx_r[AW-1:0];

  // keep flag per field, stored at the field's first index
  acfu_ram #(
    .WIDTH (1),
    .DEPTH (PARAM_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (start_r[AW-1:0]),
    .wdata (keep_cur),
    .raddr (idx_r[AW-1:0]),
    .rdata (f_rdata)
  );

  assign is_digit = (ram_rdata >= acfu_pkg::CH_DIGIT_0) && (ram_rdata <= acfu_pkg::CH_DIGIT_9);
  assign is_blank = (ram_rdata == acfu_pkg::CH_SPACE)
                    || (ram_rdata >= acfu_pkg::CH_TAB && ram_rdata <= acfu_pkg::CH_CR);
  assign is_sign  = (ram_rdata == acfu_pkg::CH_PLUS) || (ram_rdata == acfu_pkg::CH_MINUS);
  assign mag_sum  = 9'(mag_r) * 9'd10 + 9'(ram_rdata[3:0]);
  assign mag_step = (mag_sum >= 9'(acfu_pkg::KEEP_LIMIT)) ? acfu_pkg::KEEP_LIMIT : mag_sum[4:0];
  assign keep_cur = (neg_r && mag_r != '0) || (mag_r < acfu_pkg::KEEP_LIMIT);

  assign res_push  = emit_v && !res_full;
  assign res.data  = emit_data;
  assign res.last  = emit_last;

  always_comb begin
    state_nxt    = state_r;
    tail_nxt     = tail_r;
    walk_nxt     = walk_r;
    is_m_nxt     = is_m_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    start_nxt    = start_r;
    ph_nxt       = ph_r;
    nonempty_nxt = nonempty_r;
    ev_nxt       = ev_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    any_nxt      = any_r;
    at_start_nxt = at_start_r;
    keep_nxt     = keep_r;
    emitted_nxt  = emitted_r;
    cmd_pop      = 1'b0;
    emit_v       = 1'b0;
    emit_last    = 1'b0;
    emit_data    = ram_rdata;
    scan_end     = 1'b0;
    f_we         = 1'b0;
    walk_done    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop      = 1'b1;
          tail_nxt     = cmd.data;
          walk_nxt     = 1'b0;
          is_m_nxt     = 1'b0;
          cnt_nxt      = CW'(cmd.count);
          idx_nxt      = '0;
          ph_nxt       = 1'b0;
          start_nxt    = '0;
          nonempty_nxt = 1'b0;
          ev_nxt       = EV_BLANK;
          neg_nxt      = 1'b0;
          mag_nxt      = '0;
          any_nxt      = 1'b0;
          unique case (cmd.op)
            acfu_pkg::OP_BYTE:     state_nxt = ST_TAIL;
            acfu_pkg::OP_ESC_BYTE: state_nxt = ST_ESC;
            acfu_pkg::OP_SGR: begin
              walk_nxt  = 1'b1;
              is_m_nxt  = 1'b1;
              tail_nxt  = acfu_pkg::CH_M;
              state_nxt = ST_SCAN;
            end
            default: begin
              walk_nxt  = 1'b1;
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!ph_r) begin
          if (idx_r == cnt_r) begin
            scan_end = 1'b1;
          end else begin
            ph_nxt = 1'b1;
          end
        end else if (ram_rdata == acfu_pkg::CH_NUL) begin
          scan_end = 1'b1;
        end else begin
          if (ram_rdata == acfu_pkg::CH_SEMI) begin
            f_we         = nonempty_r;
            any_nxt      = any_r | (nonempty_r & keep_cur);
            start_nxt    = idx_r + 1'b1;
            nonempty_nxt = 1'b0;
            ev_nxt       = EV_BLANK;
            neg_nxt      = 1'b0;
            mag_nxt      = '0;
          end else begin
            nonempty_nxt = 1'b1;
            unique case (ev_r)
              EV_BLANK: begin
                if (is_sign) begin
                  neg_nxt = (ram_rdata == acfu_pkg::CH_MINUS);
                  ev_nxt  = EV_DIGIT;
                end else if (is_digit) begin
                  mag_nxt = mag_step;
                  ev_nxt  = EV_DIGIT;
                end else if (!is_blank) begin
                  ev_nxt = EV_DONE;
                end
              end
              EV_DIGIT: begin
                if (is_digit) begin
                  mag_nxt = mag_step;
                end else begin
                  ev_nxt = EV_DONE;
                end
              end
              default: ev_nxt = ev_r;
            endcase
          end
          idx_nxt = idx_r + 1'b1;
          ph_nxt  = 1'b0;
        end
        if (scan_end) begin
          f_we         = nonempty_r;
          len_nxt      = idx_r;
          idx_nxt      = '0;
          ph_nxt       = 1'b0;
          at_start_nxt = 1'b1;
          keep_nxt     = 1'b0;
          emitted_nxt  = 1'b0;
          if (is_m_r ? (any_r | (nonempty_r & keep_cur)) : (idx_r != '0)) begin
            state_nxt = ST_ESC;
          end else begin
            state_nxt = ST_IDLE;
            walk_done = 1'b1;
          end
        end
      end

      ST_ESC: begin
        emit_v    = 1'b1;
        emit_data = acfu_pkg::CH_ESC;
        if (!res_full) begin
          state_nxt = walk_r ? ST_LB : ST_TAIL;
        end
      end

      ST_LB: begin
        emit_v    = 1'b1;
        emit_data = acfu_pkg::CH_LBRACKET;
        if (!res_full) begin
          state_nxt = ST_COPY;
        end
      end

      ST_COPY: begin
        if (!ph_r) begin
          if (idx_r == len_r) begin
            state_nxt = ST_TAIL;
          end else begin
            ph_nxt = 1'b1;
          end
        end else if (!is_m_r) begin
          emit_v = 1'b1;
          if (!res_full) begin
            idx_nxt = idx_r + 1'b1;
            ph_nxt  = 1'b0;
          end
        end else if (ram_rdata == acfu_pkg::CH_SEMI) begin
          at_start_nxt = 1'b1;
          idx_nxt      = idx_r + 1'b1;
          ph_nxt       = 1'b0;
        end else if (at_start_r) begin
          if (f_rdata[0]) begin
            emit_v = 1'b1;
            if (emitted_r) begin
              // separator first, the field byte follows once the separator is taken
              emit_data = acfu_pkg::CH_SEMI;
              if (!res_full) begin
                at_start_nxt = 1'b0;
                keep_nxt     = 1'b1;
              end
            end else if (!res_full) begin
              at_start_nxt = 1'b0;
              keep_nxt     = 1'b1;
              emitted_nxt  = 1'b1;
              idx_nxt      = idx_r + 1'b1;
              ph_nxt       = 1'b0;
            end
          end else begin
            at_start_nxt = 1'b0;
            keep_nxt     = 1'b0;
            idx_nxt      = idx_r + 1'b1;
            ph_nxt       = 1'b0;
          end
        end else if (keep_r) begin
          emit_v = 1'b1;
          if (!res_full) begin
            emitted_nxt = 1'b1;
            idx_nxt     = idx_r + 1'b1;
            ph_nxt      = 1'b0;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          ph_nxt  = 1'b0;
        end
      end

      ST_TAIL: begin
        emit_v    = 1'b1;
        emit_data = tail_r;
        emit_last = 1'b1;
        if (!res_full) begin
          state_nxt = ST_IDLE;
          walk_done = walk_r;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r     <= tail_nxt;
    walk_r     <= walk_nxt;
    is_m_r     <= is_m_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    start_r    <= start_nxt;
    ph_r       <= ph_nxt;
    nonempty_r <= nonempty_nxt;
    ev_r       <= ev_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    any_r      <= any_nxt;
    at_start_r <= at_start_nxt;
    keep_r     <= keep_nxt;
    emitted_r  <= emitted_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/ansi_color_code_filter_unit.sv =====
// top level of the ansi color code filter: config register, front, queues, back
// depends on acfu_pkg, acfu_front, acfu_back, acfu_fifo, acfu_ram
//
//   channel   ports                                   request moves
//   input     push, full, in_text_byte                one text byte
//   result    pop, empty, out_byte, out_last_of_run   one filtered byte
//   config    psel, penable, pwrite, paddr, pwdata    pass_through at address 0
//
// a plain byte passes the back end through idle and tail; an esc pair through idle, esc and tail
// a csi end is scanned byte by byte up to the stored count or a zero byte, then esc, [, the kept
// bytes with a separator added between kept sgr fields, and the final byte are emitted; with nothing
// to re-emit only the scan runs; the back end reads each parameter byte in an address and a data phase
// while a csi end is walked, parameter bytes of the next csi sequence wait at full
// synchronous reset clears mode, count, queues and the back-end state; no clearing pass
`default_nettype none

module ansi_color_code_filter_unit #(
  parameter int PARAM_DEPTH = acfu_pkg::PARAM_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        pop,
  output logic             empty,
  output logic      [7:0]  out_byte,
  output logic             out_last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(PARAM_DEPTH);

  logic             pass_through_r, pass_through_nxt;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  acfu_pkg::cmd_t   cmd_in, cmd_out;
  logic [$bits(acfu_pkg::cmd_t)-1:0] cmd_rdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             walk_done;
  logic             res_push, res_full;
  acfu_pkg::res_t   res_in, res_out;
  logic [$bits(acfu_pkg::res_t)-1:0] res_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == acfu_pkg::REG_PASS_THROUGH) ? {31'b0, pass_through_r} : '0;

  always_comb begin
    pass_through_nxt = pass_through_r;
    if (psel && penable && pwrite && paddr[2] == acfu_pkg::REG_PASS_THROUGH) begin
      pass_through_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_through_r <= 1'b0;
    end else begin
      pass_through_r <= pass_through_nxt;
    end
  end

  acfu_front #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .pass_through (pass_through_r),
    .in_push      (push),
    .in_byte      (in_text_byte),
    .in_full      (full),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .walk_done    (walk_done)
  );

  acfu_ram #(
    .WIDTH (8),
    .DEPTH (PARAM_DEPTH)
  ) u_param_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  acfu_fifo #(
    .WIDTH ($bits(acfu_pkg::cmd_t)),
    .DEPTH (acfu_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .rd_en (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign cmd_out = acfu_pkg::cmd_t'(cmd_rdata);

  acfu_back #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .walk_done (walk_done)
  );

  acfu_fifo #(
    .WIDTH ($bits(acfu_pkg::res_t)),
    .DEPTH (acfu_pkg::RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (res_push),
    .wdata (res_in),
    .full  (res_full),
    .rd_en (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out         = acfu_pkg::res_t'(res_rdata);
  assign out_byte        = res_out.data;
  assign out_last_of_run = res_out.last;

endmodule

`default_nettype wire

// ===== hdl/acfu_checker.sv =====
// port-level checks on the ansi color code filter, bound to the top level
// depends on assert_macros.svh, ansi_color_code_filter_unit
`default_nettype none
`include "assert_macros.svh"

module acfu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_run
);

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, empty, "result queue not empty after reset")

  `ASSERT_NEXT_ALWAYS(a_reset_ready, clk, !rst_n, !full, "input not ready after reset")

  `ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last_of_run), "waiting result changed")

endmodule

bind ansi_color_code_filter_unit acfu_checker u_acfu_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench for ansi_color_code_filter_unit: drives text bytes, predicts the filtered
// byte stream in place and checks every popped result field by field
// depends on acfu_pkg and the rtl of the filter unit

module testbench;

  localparam int DEPTH = acfu_pkg::PARAM_DEPTH;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 500000;
  localparam int MAG_CAP = 1000;
  localparam logic [2:0] ADDR_PASS_THROUGH = {acfu_pkg::REG_PASS_THROUGH, 2'b00};

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_CSI
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } filtered_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_text_byte = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  parse_mode_t mode_q = MODE_TEXT;
  logic [7:0]  params_q [DEPTH];
  int          param_len_q = 0;
  logic        pass_q = 1'b0;
  filtered_t   expected_out [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;

  ansi_color_code_filter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_text_byte   (in_text_byte),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Verification failed");
    $finish;
  end

  function automatic logic alpha_byte(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic blank_byte(input logic [7:0] b);
    return b == acfu_pkg::CH_SPACE || (b >= acfu_pkg::CH_TAB && b <= acfu_pkg::CH_CR);
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    return b >= acfu_pkg::CH_DIGIT_0 && b <= acfu_pkg::CH_DIGIT_9;
  endfunction

  // decimal value of params_q[s..e) below the keep limit, or negative
  function automatic logic field_below_limit(input int s, input int e);
    int i;
    int mag;
    logic neg;
    i = s;
    mag = 0;
    neg = 1'b0;
    while (i < e && blank_byte(params_q[i])) i++;
    if (i < e && (params_q[i] == acfu_pkg::CH_MINUS
                  || params_q[i] == acfu_pkg::CH_PLUS)) begin
      neg = params_q[i] == acfu_pkg::CH_MINUS;
      i++;
    end
    while (i < e && digit_byte(params_q[i])) begin
      mag = mag * 10 + int'(params_q[i] - acfu_pkg::CH_DIGIT_0);
      if (mag > MAG_CAP) mag = MAG_CAP;
      i++;
    end
    return (neg && mag > 0) || mag < int'(acfu_pkg::KEEP_LIMIT);
  endfunction

  task automatic predict_filter(input logic [7:0] b);
    logic [7:0] run_bytes [$];
    logic [7:0] kept [$];
    int len;
    int s;
    int e;
    if (pass_q) begin
      run_bytes.push_back(b);
    end else if (mode_q == MODE_ESC) begin
      if (b == acfu_pkg::CH_LBRACKET) begin
        mode_q = MODE_CSI;
      end else begin
        mode_q = MODE_TEXT;
        run_bytes.push_back(acfu_pkg::CH_ESC);
        run_bytes.push_back(b);
      end
    end else if (mode_q == MODE_CSI) begin
      if (b != acfu_pkg::CH_M && param_len_q < DEPTH && !alpha_byte(b)) begin
        params_q[param_len_q] = b;
        param_len_q++;
      end else begin
        len = 0;
        while (len < param_len_q && params_q[len] != acfu_pkg::CH_NUL) len++;
        if (b == acfu_pkg::CH_M) begin
          s = 0;
          while (s < len) begin
            e = s;
            while (e < len && params_q[e] != acfu_pkg::CH_SEMI) e++;
            if (e > s && field_below_limit(s, e)) begin
              if (kept.size() > 0 && kept.size() < DEPTH)
                kept.push_back(acfu_pkg::CH_SEMI);
              for (int i = s; i < e && kept.size() < DEPTH; i++) kept.push_back(params_q[i]);
            end
            s = e + 1;
          end
          if (kept.size() > 0) begin
            run_bytes.push_back(acfu_pkg::CH_ESC);
            run_bytes.push_back(acfu_pkg::CH_LBRACKET);
            foreach (kept[i]) run_bytes.push_back(kept[i]);
            run_bytes.push_back(acfu_pkg::CH_M);
          end
        end else if (len > 0) begin
          run_bytes.push_back(acfu_pkg::CH_ESC);
          run_bytes.push_back(acfu_pkg::CH_LBRACKET);
          for (int i = 0; i < len; i++) run_bytes.push_back(params_q[i]);
          run_bytes.push_back(b);
        end
        param_len_q = 0;
        mode_q = MODE_TEXT;
      end
    end else begin
      mode_q = MODE_TEXT;
      if (b == acfu_pkg::CH_ESC) mode_q = MODE_ESC;
      else run_bytes.push_back(b);
    end
    foreach (run_bytes[i])
      expected_out.push_back('{data: run_bytes[i], last: i == run_bytes.size() - 1});
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_filter(b);
  endtask

  task automatic send_string(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pass_through(input logic value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PASS_THROUGH;
    pwdata <= {31'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pass_q = value;
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    filtered_t want;
    if (rst_n && pop && !empty) begin
      if (expected_out.size() == 0) begin
        flag_mismatch($sformatf("out_byte expected none actual %h", out_byte));
      end else begin
        want = expected_out.pop_front();
        if (out_byte !== want.data)
          flag_mismatch($sformatf("out_byte expected %h actual %h", want.data, out_byte));
        if (out_last_of_run !== want.last)
          flag_mismatch($sformatf("out_last_of_run expected %b actual %b",
                                  want.last, out_last_of_run));
      end
    end
    pop <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] letter_byte();
    return ($urandom_range(1) != 0 ? 8'h41 : 8'h61) + 8'($urandom_range(25));
  endfunction

  // parameter byte, mostly digits and separators
  function automatic logic [7:0] param_byte();
    logic [7:0] b;
    case ($urandom_range(15))
      8, 9: b = acfu_pkg::CH_SEMI;
      10: b = ($urandom_range(1) != 0) ? acfu_pkg::CH_SPACE
                                       : acfu_pkg::CH_TAB + 8'($urandom_range(4));
      11: b = ($urandom_range(1) != 0) ? acfu_pkg::CH_MINUS : acfu_pkg::CH_PLUS;
      12: b = ($urandom_range(3) == 0) ? acfu_pkg::CH_NUL
                                       : acfu_pkg::CH_DIGIT_0 + 8'($urandom_range(9));
      13, 14, 15: begin
        do b = 8'($urandom_range(255)); while (alpha_byte(b));
      end
      default: b = acfu_pkg::CH_DIGIT_0 + 8'($urandom_range(9));
    endcase
    return b;
  endfunction

  task automatic send_random_run(output int sent);
    int kind;
    int n;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_byte(8'($urandom_range(255)));
      sent = 1;
    end else if (kind < 35) begin
      do b = 8'($urandom_range(255)); while (b == acfu_pkg::CH_LBRACKET);
      send_byte(acfu_pkg::CH_ESC);
      send_byte(b);
      sent = 2;
    end else begin
      n = ($urandom_range(7) == 0) ? $urandom_range(27, 20) : $urandom_range(6);
      send_byte(acfu_pkg::CH_ESC);
      send_byte(acfu_pkg::CH_LBRACKET);
      repeat (n) send_byte(param_byte());
      send_byte(($urandom_range(3) != 0) ? acfu_pkg::CH_M : letter_byte());
      sent = n + 3;
    end
    if ($urandom_range(39) == 0) begin
      push <= 1'b0;
      while (expected_out.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_plain_and_escape();
    send_byte(acfu_pkg::CH_NUL);
    send_byte(8'hFF);
    send_byte(acfu_pkg::CH_ESC);
    send_byte(acfu_pkg::CH_ESC);
    send_byte(acfu_pkg::CH_ESC);
    send_byte("x");
  endtask

  task automatic test_color_filtering();
    send_byte(acfu_pkg::CH_ESC);
    send_string("[31;5m");
    send_byte(acfu_pkg::CH_ESC);
    send_string("[;");
    send_byte(acfu_pkg::CH_TAB);
    send_string("-4;40m");
  endtask

  task automatic test_other_final_bytes();
    send_byte(acfu_pkg::CH_ESC);
    send_string("[1");
    send_byte(acfu_pkg::CH_NUL);
    send_string("2H");
    send_byte(acfu_pkg::CH_ESC);
    send_string("[H");
  endtask

  // open csi sequence survives a stretch of copied bytes
  task automatic test_pass_through();
    send_byte(acfu_pkg::CH_ESC);
    send_string("[2");
    write_pass_through(1'b1);
    send_byte(acfu_pkg::CH_ESC);
    send_byte(acfu_pkg::CH_LBRACKET);
    repeat (28) send_byte(8'($urandom_range(255)));
    write_pass_through(1'b0);
    send_string(";3m");
  endtask

  task automatic test_random_stream(input int idle, input int stall, input int count);
    int sent;
    int total;
    idle_pct = idle;
    stall_pct = stall;
    total = 0;
    while (total < count) begin
      send_random_run(sent);
      total += sent;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_and_escape();
    test_color_filtering();
    test_other_final_bytes();
    test_pass_through();
    test_random_stream(0, 0, 60);
    test_random_stream(83, 0, 60);
    test_random_stream(0, 83, 60);
    test_random_stream(38, 38, 60);
    wait_drained();
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
